[hdl/plbc_pkg.sv]
// Package: shared types, constants and helpers for the packed lane bit counter.
`timescale 1ns / 1ps
`default_nettype none

package plbc_pkg;

    localparam int MAX_WORD_BITS  = 64;   // port width of data and result words
    localparam int MAX_LANE       = 32;   // widest supported lane
    localparam int LANE_W_BITS    = 6;    // lane_width register width
    localparam int LANE_CNT_BITS  = 7;    // holds a lane count up to MAX_WORD_BITS
    localparam int DEF_WORD_BITS  = 64;
    localparam int RESET_LANE_W   = 8;
    localparam int ADDR_BITS      = 3;
    localparam int DATA_BITS      = 32;

    // Register byte addresses (bit 2 of paddr picks the register slot)
    localparam logic [ADDR_BITS-1:0] ADDR_LANE_WIDTH = 3'd0;

    typedef enum logic [1:0] {
        CMD_POPCNT = 2'd0,
        CMD_CTZ    = 2'd1,
        CMD_CLZ    = 2'd2
    } cmd_e;

    typedef struct packed {
        logic [1:0]               command;
        logic [MAX_WORD_BITS-1:0] data_word;
    } operand_t;

    typedef struct packed {
        logic [MAX_WORD_BITS-1:0] result_word;
        logic                     width_error;
    } result_t;

    // Control that travels with an item down the cell chain
    typedef struct packed {
        logic       valid;
        logic [1:0] cmd;
        logic       kill;     // result stays zero
        logic       werr;     // unsupported lane width
    } ctl_t;

    // Lane geometry, settled when lane_width is written
    typedef struct packed {
        logic [LANE_W_BITS-1:0]   lane_width;
        logic [LANE_CNT_BITS-1:0] lanes;       // whole lanes in the word
        logic [LANE_W_BITS-1:0]   top_shift;   // offset of the last whole lane
        logic                     width_error;
    } lane_cfg_t;

    // Index of the single set bit of a one-hot word
    function automatic logic [4:0] onehot_idx(input logic [MAX_LANE-1:0] oh);
        logic [4:0] idx;
        idx = '0;
        for (int i = 0; i < MAX_LANE; i++) begin
            if (oh[i]) begin
                idx = idx | 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

[hdl/plbc_cell.sv]
// One cell of the chain: counts the lane at the bottom of the word and packs it.
`timescale 1ns / 1ps
`default_nettype none

module plbc_cell
    import plbc_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int INDEX     = 0
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lane_cfg_t            cfg,
    input  wire ctl_t                 ctl_in,
    input  wire logic [WORD_BITS-1:0] data_in,
    input  wire logic [WORD_BITS-1:0] res_in,
    output ctl_t                      ctl_out,
    output logic [WORD_BITS-1:0]      data_out,
    output logic [WORD_BITS-1:0]      res_out
);

    localparam logic [LANE_CNT_BITS-1:0] LANE_IDX = LANE_CNT_BITS'(INDEX);

    ctl_t                 ctl_reg;
    logic [WORD_BITS-1:0] data_reg, data_next;
    logic [WORD_BITS-1:0] res_reg, res_next;

    logic [MAX_LANE-1:0]    lmask, lane, lane_rev, low_oh, rev_oh;
    logic [LANE_W_BITS-1:0] cnt;
    logic                   active;

    always_comb
    begin
        lmask = MAX_LANE'((33'd1 << cfg.lane_width) - 33'd1);
        lane  = data_in[MAX_LANE-1:0] & lmask;
        for (int i = 0; i < MAX_LANE; i++) begin
            lane_rev[i] = lane[MAX_LANE-1-i];
        end
        low_oh = lane & (~lane + 32'd1);
        rev_oh = lane_rev & (~lane_rev + 32'd1);
        unique case (cmd_e'(ctl_in.cmd))
            CMD_POPCNT: cnt = LANE_W_BITS'($countones(lane));
            CMD_CTZ:    cnt = (lane == '0) ? cfg.lane_width
                                           : {1'b0, onehot_idx(low_oh)};
            CMD_CLZ:    cnt = (lane == '0) ? cfg.lane_width
                                           : {1'b0, onehot_idx(rev_oh)}
                                             - (6'd32 - cfg.lane_width);
            default:    cnt = '0;
        endcase
    end

    // Lane k is handled by cell k; cells past the last whole lane pass through
    assign active = !ctl_in.kill && (cfg.lanes > LANE_IDX);

    always_comb
    begin
        if (active) begin
            data_next = data_in >> cfg.lane_width;
            res_next  = (res_in >> cfg.lane_width)
                      | (WORD_BITS'(cnt) << cfg.top_shift);
        end
        else begin
            data_next = data_in;
            res_next  = res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctl_reg <= '0;
        end
        else begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        res_reg  <= res_next;
    end

    assign ctl_out  = ctl_reg;
    assign data_out = data_reg;
    assign res_out  = res_reg;

endmodule

`default_nettype wire

[hdl/packed_lane_bit_counter.sv]
// Top level: packed lane popcount / trailing zeros / leading zeros over a chain of cells.
// Throughput: one item per clock; start is taken every cycle, busy is always low.
// done rises once the item has passed the whole chain of registered cells,
//   one cell for each possible lane (lane width 1 gives WORD_BITS lanes).
// Results appear on result for exactly one cycle with done; there is no back-pressure.
// Reset (rst_n low, async): pipeline valids cleared, lane_width returns to 8.
`timescale 1ns / 1ps
`default_nettype none

module packed_lane_bit_counter
    import plbc_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS   // 32..64
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // item channel
    input  wire logic                 start,
    output logic                      busy,
    input  wire operand_t             operand,
    output logic                      done,
    output result_t                   result,
    // APB configuration port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0]      prdata,
    output logic                      pready
);

    localparam int NCELL = WORD_BITS;

    // Lane geometry after reset (lane width 8)
    localparam int RST_LANES = WORD_BITS / RESET_LANE_W;
    localparam lane_cfg_t CFG_RESET = '{
        lane_width:  LANE_W_BITS'(RESET_LANE_W),
        lanes:       LANE_CNT_BITS'(RST_LANES),
        top_shift:   LANE_W_BITS'(RST_LANES * RESET_LANE_W - RESET_LANE_W),
        width_error: 1'b0
    };

    // ------------------------------------------------------------------
    // Configuration: lane count and the last lane's offset come from a
    // constant table indexed by the written width, so the chain never
    // divides at run time.
    // ------------------------------------------------------------------
    lane_cfg_t cfg_reg, cfg_next;
    lane_cfg_t geom_tab [0:(1 << LANE_W_BITS)-1];
    logic      cfg_write;

    for (genvar g = 0; g < (1 << LANE_W_BITS); g++) begin : g_geom
        localparam bit OK   = (g >= 1) && (g <= MAX_LANE);
        localparam int DIVW = OK ? g : 1;
        localparam int LN   = OK ? (WORD_BITS / DIVW) : 0;
        localparam int TS   = OK ? (LN * DIVW - DIVW) : 0;
        assign geom_tab[g] = '{
            lane_width:  LANE_W_BITS'(g),
            lanes:       LANE_CNT_BITS'(LN),
            top_shift:   LANE_W_BITS'(TS),
            width_error: !OK
        };
    end

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                    && (paddr[2] == ADDR_LANE_WIDTH[2]);
    assign cfg_next  = geom_tab[pwdata[LANE_W_BITS-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_write) begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == ADDR_LANE_WIDTH[2]) begin
            prdata = DATA_BITS'(cfg_reg.lane_width);
        end
    end

    // ------------------------------------------------------------------
    // Cell chain. Each cell consumes the lane at the bottom of the data
    // word, shifts the word down by one lane and slides its count into
    // the result from the top, so lane 0 lands at bit 0 at the end.
    // ------------------------------------------------------------------
    ctl_t                 ctl_chain  [0:NCELL];
    logic [WORD_BITS-1:0] data_chain [0:NCELL];
    logic [WORD_BITS-1:0] res_chain  [0:NCELL];
    logic                 cmd_ok;

    assign busy   = 1'b0;
    assign cmd_ok = (operand.command == CMD_POPCNT) || (operand.command == CMD_CTZ)
                 || (operand.command == CMD_CLZ);

    assign ctl_chain[0] = '{
        valid: start && !busy,
        cmd:   operand.command,
        kill:  cfg_reg.width_error || !cmd_ok,
        werr:  cfg_reg.width_error
    };

    assign data_chain[0] = operand.data_word[WORD_BITS-1:0];
    assign res_chain[0]  = '0;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        plbc_cell #(
            .WORD_BITS (WORD_BITS),
            .INDEX     (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cfg      (cfg_reg),
            .ctl_in   (ctl_chain[k]),
            .data_in  (data_chain[k]),
            .res_in   (res_chain[k]),
            .ctl_out  (ctl_chain[k+1]),
            .data_out (data_chain[k+1]),
            .res_out  (res_chain[k+1])
        );
    end

    // Last cell's registers drive the result directly
    assign done               = ctl_chain[NCELL].valid;
    assign result.result_word = MAX_WORD_BITS'(res_chain[NCELL]);
    assign result.width_error = ctl_chain[NCELL].werr;

endmodule

`default_nettype wire

[hdl/plbc_checker.sv]
// Checker: port-level assertions for the packed lane bit counter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module plbc_checker
    import plbc_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
)(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 done,
    input wire result_t              result,
    input wire logic                 psel,
    input wire logic                 penable,
    input wire logic                 pwrite,
    input wire logic [ADDR_BITS-1:0] paddr,
    input wire logic [DATA_BITS-1:0] pwdata,
    input wire logic [DATA_BITS-1:0] prdata,
    input wire logic                 pready
);

    localparam int WARM     = WORD_BITS + 1;
    localparam int WARM_BITS = $clog2(WARM + 1);

    // Edges since reset release, saturating once the chain is full of post-reset items
    logic [WARM_BITS-1:0] warm_reg, warm_next;

    assign warm_next = (warm_reg == WARM_BITS'(WARM)) ? warm_reg : warm_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            warm_reg <= '0;
        end
        else begin
            warm_reg <= warm_next;
        end
    end

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (warm_reg == WARM_BITS'(WARM)) |-> (done == $past(start && !busy, WORD_BITS)))
        else $error("done does not follow start by the chain latency");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.width_error) |-> (result.result_word == '0))
        else $error("nonzero result with width error");

    a_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.result_word >> WORD_BITS) == '0))
        else $error("result bits above the word are set");

    a_cfg_read: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && !paddr[2]) |=>
        (paddr[2] || (prdata == DATA_BITS'($past(pwdata[LANE_W_BITS-1:0])))))
        else $error("lane_width readback mismatch");

endmodule

bind packed_lane_bit_counter plbc_checker #(.WORD_BITS(WORD_BITS)) u_plbc_checker (.*);

`default_nettype wire

[dv/packed_lane_bit_counter_tb.sv]
// Testbench: packed_lane_bit_counter checked item by item against a lane-count predictor.
`timescale 1ns / 1ps
`default_nettype none

module packed_lane_bit_counter_tb;
    import plbc_pkg::*;

    localparam int WORD_BITS    = DEF_WORD_BITS;
    localparam int LATENCY      = WORD_BITS;      // one cell per possible lane
    localparam int CYCLE_LIMIT  = 100000;
    localparam int RANDOM_ITEMS = 1300;
    localparam logic [1:0] CMD_NONE = 2'd3;      // unused command, result zero
    localparam logic [MAX_WORD_BITS-1:0] WORD_MASK =
        (WORD_BITS >= 64) ? '1 : ((64'd1 << WORD_BITS) - 64'd1);

    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic                 start   = 1'b0;
    logic                 busy;
    operand_t             operand = '0;
    logic                 done;
    result_t              result;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr   = '0;
    logic [DATA_BITS-1:0] pwdata  = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    packed_lane_bit_counter #(.WORD_BITS(WORD_BITS)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .operand (operand),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    int unsigned            cycle_count = 0;
    int                     error_count = 0;
    result_t                pending_counts[$];   // expected results, oldest first
    logic [LANE_W_BITS-1:0] lane_width_now = LANE_W_BITS'(RESET_LANE_W);

    // Directed rows; known=1 means the expected word is typed in below
    typedef struct packed {
        logic [LANE_W_BITS-1:0]   width;
        logic [1:0]               cmd;
        logic [MAX_WORD_BITS-1:0] data;
        logic                     known;
        logic [MAX_WORD_BITS-1:0] want_word;
        logic                     want_err;
    } dir_row_t;

    localparam int DIR_ROWS = 23;
    dir_row_t dir_rows [DIR_ROWS] = '{
        // reset width 8, no register write yet
        '{6'd8,  CMD_POPCNT, 64'h0,                   1'b1, 64'h0,                   1'b0},
        '{6'd8,  CMD_POPCNT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0808_0808_0808_0808, 1'b0},
        '{6'd8,  CMD_CTZ,    64'h0,                   1'b1, 64'h0808_0808_0808_0808, 1'b0},
        '{6'd8,  CMD_CLZ,    64'h0,                   1'b1, 64'h0808_0808_0808_0808, 1'b0},
        '{6'd8,  CMD_NONE,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0,                   1'b0},
        '{6'd8,  CMD_CTZ,    64'h8040_2010_0804_0201, 1'b0, 64'h0,                   1'b0},
        '{6'd8,  CMD_CLZ,    64'h8040_2010_0804_0201, 1'b0, 64'h0,                   1'b0},
        // narrowest lane: every bit is a lane
        '{6'd1,  CMD_POPCNT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
        '{6'd1,  CMD_CTZ,    64'h0,                   1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
        '{6'd1,  CMD_CLZ,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0,                   1'b0},
        '{6'd1,  CMD_POPCNT, 64'hA5A5_5A5A_F00F_0FF0, 1'b0, 64'h0,                   1'b0},
        // widest lane
        '{6'd32, CMD_POPCNT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0000_0020_0000_0020, 1'b0},
        '{6'd32, CMD_CTZ,    64'h0,                   1'b1, 64'h0000_0020_0000_0020, 1'b0},
        '{6'd32, CMD_CLZ,    64'h0000_0001_8000_0000, 1'b1, 64'h0000_001F_0000_0000, 1'b0},
        '{6'd32, CMD_CTZ,    64'h0000_0001_8000_0000, 1'b0, 64'h0,                   1'b0},
        // refused widths: zero and above 32
        '{6'd0,  CMD_POPCNT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0,                   1'b1},
        '{6'd33, CMD_CTZ,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0,                   1'b1},
        '{6'd63, CMD_CLZ,    64'h0,                   1'b1, 64'h0,                   1'b1},
        '{6'd63, CMD_NONE,   64'h0,                   1'b1, 64'h0,                   1'b1},
        // partial top lane must come back zero
        '{6'd7,  CMD_POPCNT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0,                   1'b0},
        '{6'd5,  CMD_CLZ,    64'h0,                   1'b0, 64'h0,                   1'b0},
        '{6'd24, CMD_CTZ,    64'h0000_0010_0000_1000, 1'b0, 64'h0,                   1'b0},
        '{6'd3,  CMD_NONE,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0,                   1'b0}
    };

    task automatic report_mismatch(input string what);
        error_count++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Per-lane popcount / trailing zeros / leading zeros of one word
    function automatic result_t lane_counts(input logic [1:0] cmd,
                                            input logic [MAX_WORD_BITS-1:0] word,
                                            input logic [LANE_W_BITS-1:0] w);
        result_t                  r;
        logic [MAX_WORD_BITS-1:0] lmask;
        logic [MAX_WORD_BITS-1:0] lane;
        logic [MAX_WORD_BITS-1:0] cnt;
        logic                     hit;
        int                       nlanes;
        r = '0;
        if (w == 0 || w > MAX_LANE) begin
            r.width_error = 1'b1;
            return r;
        end
        if (cmd == CMD_NONE) begin
            return r;
        end
        word   = word & WORD_MASK;
        lmask  = (64'd1 << w) - 64'd1;
        nlanes = WORD_BITS / int'(w);
        for (int k = 0; k < nlanes; k++) begin
            lane = (word >> (k * int'(w))) & lmask;
            cnt  = '0;
            hit  = 1'b0;
            for (int i = 0; i < int'(w); i++) begin
                case (cmd)
                    CMD_POPCNT: cnt += lane[i];
                    CMD_CTZ:
                    begin
                        hit = hit | lane[i];
                        if (!hit) cnt++;
                    end
                    default:    // leading zeros, scan from the lane's top bit
                    begin
                        hit = hit | lane[int'(w) - 1 - i];
                        if (!hit) cnt++;
                    end
                endcase
            end
            r.result_word |= (cnt & lmask) << (k * int'(w));
        end
        r.result_word &= WORD_MASK;
        return r;
    endfunction

    // Results are taken at the edge that ends the done cycle; sample mid-cycle
    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && done) begin
            if (pending_counts.size() == 0) begin
                report_mismatch($sformatf("unexpected result word %h err %b",
                                          result.result_word, result.width_error));
            end else begin
                want = pending_counts.pop_front();
                if (result.result_word !== want.result_word)
                    report_mismatch($sformatf("result_word %h, want %h",
                                              result.result_word, want.result_word));
                if (result.width_error !== want.width_error)
                    report_mismatch($sformatf("width_error %b, want %b",
                                              result.width_error, want.width_error));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // One APB transfer to the lane_width register; called just after a rising edge
    task automatic apb_access(input logic wr, input logic [DATA_BITS-1:0] wdata,
                              output logic [DATA_BITS-1:0] rdata);
        logic ready;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_LANE_WIDTH;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do begin
            @(negedge clk);
            ready = pready;
            rdata = prdata;
            @(posedge clk);
        end while (!ready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop issuing and let every outstanding item come back
    task automatic drain_items();
        start <= 1'b0;
        while (pending_counts.size() != 0) @(posedge clk);
    endtask

    // Change lane width while idle; junk in the upper data bits must be dropped
    task automatic change_lane_width(input logic [LANE_W_BITS-1:0] w);
        logic [DATA_BITS-1:0] junk;
        logic [DATA_BITS-1:0] readback;
        drain_items();
        junk = $urandom();
        if ($urandom_range(0, 1)) junk = '0;
        apb_access(1'b1, {junk[DATA_BITS-1:LANE_W_BITS], w}, readback);
        // idle between transfers
        @(posedge clk);
        apb_access(1'b0, '0, readback);
        if (readback !== {{(DATA_BITS - LANE_W_BITS){1'b0}}, w})
            report_mismatch($sformatf("lane_width reads %h, wrote %0d", readback, w));
        lane_width_now = w;
    endtask

    // Issue one item, wait for it to be taken, then, unless steady, maybe idle before the next
    task automatic send_item(input logic [1:0] cmd, input logic [MAX_WORD_BITS-1:0] data,
                             input logic known, input result_t want, input bit steady);
        logic taken;
        int   gap;
        start             <= 1'b1;
        operand.command   <= cmd;
        operand.data_word <= data;
        do begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end while (!taken);
        pending_counts.push_back(known ? want : lane_counts(cmd, data, lane_width_now));
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [MAX_WORD_BITS-1:0] random_word();
        logic [MAX_WORD_BITS-1:0] a;
        logic [MAX_WORD_BITS-1:0] b;
        a = {$urandom(), $urandom()};
        b = {$urandom(), $urandom()};
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return a & b & {$urandom(), $urandom()};   // sparse, long zero runs
            3:       return a | b;                             // dense
            4:       return (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
            5:       return a >> $urandom_range(0, 63);
            default: return a;
        endcase
    endfunction

    function automatic logic [1:0] random_cmd();
        case ($urandom_range(0, 9))
            0, 1, 2: return CMD_POPCNT;
            3, 4, 5: return CMD_CTZ;
            6, 7, 8: return CMD_CLZ;
            default: return CMD_NONE;
        endcase
    endfunction

    initial
    begin
        result_t                want;
        logic [LANE_W_BITS-1:0] w;
        int                     sent;
        int                     phase;
        int                     nitems;
        int                     pause_at;
        bit                     steady;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: table walk, register written whenever a row asks a new width
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].width != lane_width_now) change_lane_width(dir_rows[i].width);
            want.result_word = dir_rows[i].want_word;
            want.width_error = dir_rows[i].want_err;
            send_item(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].known, want, 1'b0);
        end

        // Random part: phases at random widths, mostly legal ones
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                w = $urandom_range(0, 1) ? 6'd0 : LANE_W_BITS'($urandom_range(33, 63));
            else
                w = LANE_W_BITS'($urandom_range(1, MAX_LANE));
            change_lane_width(w);
            nitems   = $urandom_range(40, 160);
            steady   = ($urandom_range(0, 3) == 0);
            pause_at = (phase == 0 || $urandom_range(0, 2) == 0) ?
                       $urandom_range(1, nitems - 1) : -1;
            for (int j = 0; j < nitems; j++) begin
                // hold off mid-phase until everything issued has come back
                if (j == pause_at) drain_items();
                send_item(random_cmd(), random_word(), 1'b0, '0, steady);
                sent++;
            end
            phase++;
        end

        drain_items();
        repeat (LATENCY + 8) @(posedge clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
